// ===== rtl/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants of the 3x3 RGB box blur
// Pixel and item formats, frame size limits, register indexes and the
// reciprocal table used for the truncated mean.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W  = 11;
	localparam int ROW_W  = 13;
	localparam int PEND_W = 11;
	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int CFG_W  = 13;
	localparam int SUM_W  = 12;
	localparam int CNT_W  = 4;
	localparam int RCP_W  = 17;
	localparam int RCP_SH = 16;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(640);
	localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic       op;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_last;
	} out_item_t;

	// Width clamped to 1..MAX_WIDTH.
	function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] w);
		logic [COL_W-1:0] r;
		r = w;
		if (w == '0) r = COL_W'(1);
		if (w > COL_W'(MAX_WIDTH)) r = COL_W'(MAX_WIDTH);
		return r;
	endfunction

	// Height clamped to 1..MAX_HEIGHT.
	function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] h);
		logic [ROW_W-1:0] r;
		r = h;
		if (h == '0) r = ROW_W'(1);
		if (h > ROW_W'(MAX_HEIGHT)) r = ROW_W'(MAX_HEIGHT);
		return r;
	endfunction

	// Rounded-up 2^16/n; exact truncated quotient for sums below 2^12.
	function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RCP_W-1:0] r;
		case (n)
			CNT_W'(2): r = RCP_W'(32768);
			CNT_W'(3): r = RCP_W'(21846);
			CNT_W'(4): r = RCP_W'(16384);
			CNT_W'(6): r = RCP_W'(10923);
			CNT_W'(9): r = RCP_W'(7282);
			default:   r = RCP_W'(65536);
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/bbr_ram.sv =====
// ----------------------------------------------------------------------------
// bbr_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bbr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bbr_mean.sv =====
// ----------------------------------------------------------------------------
// bbr_mean: truncated mean over the in-frame part of the 3x3 window
// Sums are registered with the reciprocal of the pixel count; the quotient
// comes from one multiply per channel on those registers.
// ----------------------------------------------------------------------------
module bbr_mean (
	input  logic                      clk,
	input  logic                      go,
	input  bbr_pkg::pix_t [8:0]       win,
	input  logic [bbr_pkg::COL_W-1:0] x,
	input  logic [bbr_pkg::ROW_W-1:0] y,
	input  logic [bbr_pkg::COL_W-1:0] w,
	input  logic [bbr_pkg::ROW_W-1:0] h,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue
);
	import bbr_pkg::*;

	logic [SUM_W-1:0] sr, sg, sb;
	logic [CNT_W-1:0] n;
	logic             use_l, use_r, use_t, use_b;
	logic [1:0]       ncol, nrow;
	logic [SUM_W-1:0] sum_r_s1, sum_g_s1, sum_b_s1;
	logic [RCP_W-1:0] rcp_s1;
	logic [SUM_W+RCP_W-1:0] pr, pg, pb;

	// Which window columns and rows lie inside the frame.
	always_comb begin
		use_l = (x != '0);
		use_r = (COL_W'(x + COL_W'(1)) < w);
		use_t = (y != '0);
		use_b = (ROW_W'(y + ROW_W'(1)) < h);
		ncol  = 2'd1 + {1'b0, use_l} + {1'b0, use_r};
		nrow  = 2'd1 + {1'b0, use_t} + {1'b0, use_b};
		n     = CNT_W'(ncol) * CNT_W'(nrow);
	end

	// Masked channel sums; entry index is column*3 + row.
	always_comb begin
		sr = '0;
		sg = '0;
		sb = '0;
		for (int i = 0; i < 9; i++) begin
			if (!((i / 3 == 0 && !use_l) || (i / 3 == 2 && !use_r) ||
				  (i % 3 == 0 && !use_t) || (i % 3 == 2 && !use_b))) begin
				sr = sr + SUM_W'(win[i].red);
				sg = sg + SUM_W'(win[i].green);
				sb = sb + SUM_W'(win[i].blue);
			end
		end
	end

	// Sum stage.
	always_ff @(posedge clk) begin
		if (go) begin
			sum_r_s1 <= sr;
			sum_g_s1 <= sg;
			sum_b_s1 <= sb;
			rcp_s1   <= recip(n);
		end
	end

	// Division by reciprocal multiply.
	assign pr    = (SUM_W+RCP_W)'(sum_r_s1) * (SUM_W+RCP_W)'(rcp_s1);
	assign pg    = (SUM_W+RCP_W)'(sum_g_s1) * (SUM_W+RCP_W)'(rcp_s1);
	assign pb    = (SUM_W+RCP_W)'(sum_b_s1) * (SUM_W+RCP_W)'(rcp_s1);
	assign red   = pr[RCP_SH+7:RCP_SH];
	assign green = pg[RCP_SH+7:RCP_SH];
	assign blue  = pb[RCP_SH+7:RCP_SH];

endmodule

// ===== rtl/box_blur_3x3_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_unit: streaming 3x3 box blur of one RGB frame
// Line stores in RAM, a 3x3 window in registers and a sequencer that steps
// one stream position at a time.
// ----------------------------------------------------------------------------
// Usage:
// Write frame_width (index 0) and frame_height (index 1) on the cfg channel
// while the block is idle. Send pixels in raster order with op = pixel, then
// drain requests (op = drain) until the result with frame_last set appears.
// Pixel requests that arrive while a drain is pending are dropped, as are
// drain requests outside a drain.
// Sequencing: each stream position is a read of both line stores, then a
// window update with a write-back for pixel positions; the RAM read data is
// registered ahead of the update. A pixel request also passes the mean and
// divide stages when it yields a result, and a new request is accepted only
// in idle. A drain request steps the same way and, when its first position
// gives no output, moves on to one more position.
// The output stream lags the input by W+1 positions (W for one-row frames).
// Reset clears counters, window and output valid; line stores hold no reset
// value. A stalled output keeps its result in the output register while the
// next request is accepted; the sequencer waits in the divide stage if full.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bbr_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bbr_pkg::out_item_t        out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [bbr_pkg::CFG_W-1:0] cfg_data
);
	import bbr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADV_A,
		S_ADV_B,
		S_ADV_C,
		S_DIV
	} state_t;

	state_t           state_q;
	logic [COL_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [COL_W-1:0] w;
	logic [ROW_W-1:0] h;
	logic [COL_W-1:0] col_q, cur_c_q, wc, c1;
	logic [ROW_W-1:0] row_q, cur_r_q, wr, r1;
	logic [PEND_W-1:0] pend_q, pend_start, pend_dec;
	pix_t [8:0]       win_q;
	pix_t             pix_q;
	logic             have_q, try_q, pre_q, last_q;
	logic             pre, post;
	pix_t             up_rd, mid_rd;
	logic             ram_we, ram_re;
	logic             mean_go;
	logic [COL_W-1:0] mean_x;
	logic [ROW_W-1:0] mean_y;
	logic [7:0]       m_red, m_green, m_blue;
	out_item_t        out_q;
	logic             out_valid_q;
	logic             out_free;

	assign w          = eff_width(width_q);
	assign h          = eff_height(height_q);
	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;
	assign out_free   = !out_valid_q || out_ready;
	assign pend_start = (h == ROW_W'(1)) ? PEND_W'(w) : PEND_W'(w + COL_W'(1));
	assign pend_dec   = pend_q - PEND_W'(1);

	// Position wrapped into the current width, and the next position.
	always_comb begin
		wc = col_q;
		wr = row_q;
		if (col_q >= w) begin
			wc = '0;
			wr = row_q + ROW_W'(1);
		end
		c1 = cur_c_q + COL_W'(1);
		r1 = cur_r_q;
		if (c1 >= w) begin
			c1 = '0;
			r1 = cur_r_q + ROW_W'(1);
		end
		pre  = (wc == '0) && (wr >= ROW_W'(2));
		post = (cur_c_q != '0) && (cur_r_q != '0);
	end

	// Line store accesses.
	assign ram_re = (state_q == S_ADV_A);
	assign ram_we = (state_q == S_ADV_B) && have_q;

	bbr_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_c_q[ADDR_W-1:0]),
		.wdata (mid_rd),
		.re    (ram_re),
		.raddr (wc[ADDR_W-1:0]),
		.rdata (up_rd)
	);

	bbr_ram #(.WIDTH($bits(pix_t)), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cur_c_q[ADDR_W-1:0]),
		.wdata (pix_q),
		.re    (ram_re),
		.raddr (wc[ADDR_W-1:0]),
		.rdata (mid_rd)
	);

	// Mean request: previous row end before the shift, or the column behind.
	always_comb begin
		mean_go = 1'b0;
		mean_x  = cur_c_q - COL_W'(1);
		mean_y  = cur_r_q - ROW_W'(1);
		if (state_q == S_ADV_A) begin
			mean_go = pre;
			mean_x  = w - COL_W'(1);
			mean_y  = wr - ROW_W'(2);
		end else if (state_q == S_ADV_C) begin
			mean_go = 1'b1;
		end
	end

	bbr_mean u_mean (
		.clk   (clk),
		.go    (mean_go),
		.win   (win_q),
		.x     (mean_x),
		.y     (mean_y),
		.w     (w),
		.h     (h),
		.red   (m_red),
		.green (m_green),
		.blue  (m_blue)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[COL_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default:          width_q  <= width_q;
			endcase
		end
	end

	// Sequencer, stream position, window and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			cur_c_q     <= '0;
			cur_r_q     <= '0;
			pend_q      <= '0;
			win_q       <= '0;
			have_q      <= 1'b0;
			try_q       <= 1'b0;
			pre_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken result empties the output unless the divide stage refills it.
			if (out_valid_q && out_ready && state_q != S_DIV) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pix_q  <= '{red: in_data.in_red, green: in_data.in_green,
							blue: in_data.in_blue};
						try_q  <= 1'b0;
						last_q <= 1'b0;
						if (in_data.op == OP_PIXEL) begin
							if (pend_q == '0) begin
								if (wr >= h) begin
									col_q  <= '0;
									row_q  <= h;
									pend_q <= pend_start;
								end else begin
									col_q   <= wc;
									row_q   <= wr;
									have_q  <= 1'b1;
									state_q <= S_ADV_A;
								end
							end
						end else if (pend_q != '0) begin
							have_q  <= 1'b0;
							state_q <= S_ADV_A;
						end
					end
				end
				S_ADV_A: begin
					col_q   <= wc;
					row_q   <= wr;
					cur_c_q <= wc;
					cur_r_q <= wr;
					pre_q   <= pre;
					state_q <= S_ADV_B;
				end
				S_ADV_B: begin
					// Shift a new column into the window.
					for (int i = 0; i < 6; i++) begin
						win_q[i] <= win_q[i+3];
					end
					win_q[6] <= up_rd;
					win_q[7] <= mid_rd;
					win_q[8] <= have_q ? pix_q : '0;
					if (have_q) begin
						if (r1 >= h) begin
							col_q  <= '0;
							row_q  <= h;
							pend_q <= pend_start;
						end else begin
							col_q <= c1;
							row_q <= r1;
						end
						if (post) state_q <= S_ADV_C;
						else if (pre_q) state_q <= S_DIV;
						else state_q <= S_IDLE;
					end else if (pre_q || post) begin
						pend_q <= pend_dec;
						last_q <= (pend_dec == '0);
						if (pend_dec == '0) begin
							col_q <= '0;
							row_q <= '0;
						end else begin
							col_q <= c1;
							row_q <= r1;
						end
						state_q <= post ? S_ADV_C : S_DIV;
					end else if (!try_q) begin
						col_q   <= c1;
						row_q   <= r1;
						try_q   <= 1'b1;
						state_q <= S_ADV_A;
					end else begin
						pend_q  <= '0;
						col_q   <= '0;
						row_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_ADV_C: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (out_free) begin
						out_q       <= '{out_red: m_red, out_green: m_green,
							out_blue: m_blue, frame_last: last_q};
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/bbr_checker.sv =====
// ----------------------------------------------------------------------------
// bbr_checker: port-level checks of the box blur
// Watches the output channel against the sequencer's timing and checks that the handshake outputs are known.
// ----------------------------------------------------------------------------
module bbr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input bbr_pkg::out_item_t out_data,
	input logic               cfg_ready
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Handshake outputs are always driven to known levels.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_ready, out_valid, cfg_ready}))
		else $error("handshake output unknown");

	// A new result comes only after the position update and the divide.
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready) && !$past(in_ready, 2) &&
			!$past(in_ready, 3))
		else $error("result without a full position update");

endmodule

bind box_blur_3x3_rgb_unit bbr_checker u_bbr_checker (.*);
